@@ rtl/fir_pkg.sv @@
// ----------------------------------------------------------------------------
// fir_pkg - shared types and constants for the FIR filter
// Field widths, request modes, defaults and the output clip range.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  localparam int SAMPLE_W = 24;          // audio sample, signed
  localparam int TAP_W    = 24;          // coefficient, signed Q2.22
  localparam int COUNT_W  = 12;          // tap_count register
  localparam int INDEX_W  = 11;          // tap_index field
  localparam int MODE_W   = 2;
  localparam int FRAC_W   = 22;          // fraction bits of a tap

  localparam int MAX_TAPS_DEF     = 2048;
  localparam int MAX_CHANNELS_DEF = 2;

  localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = 12'd1025;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

endpackage

`default_nettype wire

@@ rtl/fir_ram.sv @@
// ----------------------------------------------------------------------------
// fir_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/fir_filter_ring_history.sv @@
// ----------------------------------------------------------------------------
// fir_filter_ring_history - direct-form FIR over a per-channel history ring
// One shared 24x24 multiplier and accumulator, sequenced one tap a cycle.
// ----------------------------------------------------------------------------
// A filter request writes its sample into the channel's ring, then walks
// backwards through the ring one tap per clock through the single shared
// multiply-accumulate, and returns one rounded, saturated 24-bit sample.
// A filter request walks N taps, N being tap_count clamped to 1..MAX_TAPS;
// the length of that walk is set by the one multiplier and the one read
// port of each of the tap and history RAMs.
// A load request writes its tap at acceptance and leaves the sequencer idle;
// a clear request zeroes the channel's ring, one ring entry per clock.
// After reset a clearing pass zeroes the whole history RAM, one entry a
// cycle, all MAX_CHANNELS * 2^ceil(log2(MAX_TAPS)) entries (4096 by default),
// during which in_stall stays high; tap_count writes are taken at any time.
// in_stall is low only while the sequencer is idle. A finished result sits in
// the output register, so the next request is taken while it waits; a second
// result then waits for the output register to free up.
// Taps that were never loaded read back as whatever the RAM holds.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_ring_history #(
  parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
  parameter int MAX_CHANNELS = fir_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [fir_pkg::COUNT_W-1:0]          cfg_wdata,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fir_pkg::MODE_W-1:0]           mode,
  input  logic                                 channel,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [fir_pkg::INDEX_W-1:0]          tap_index,
  input  logic signed [fir_pkg::TAP_W-1:0]     tap_value,
  input  logic                                 block_end,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fir_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                 saturated,
  output logic                                 out_channel,
  output logic                                 last_of_block
);

  import fir_pkg::*;

  // widths derived from the parameters
  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;         // ring slot
  localparam int NW     = $clog2(MAX_TAPS + 1);                           // tap count
  localparam int CW     = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HD     = MAX_CHANNELS * (2 ** AW);                        // ring RAM depth
  localparam int HAW    = (HD > 1) ? $clog2(HD) : 1;
  localparam int PROD_W = SAMPLE_W + TAP_W;
  localparam int ACC_W  = PROD_W + AW + 1;
  localparam int QW     = ACC_W - FRAC_W;

  localparam logic signed [QW-1:0]    Q_MAX   = QW'(OUT_MAX);
  localparam logic signed [QW-1:0]    Q_MIN   = QW'(OUT_MIN);
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (FRAC_W - 1);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,   // clearing pass after reset
    S_IDLE   = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,   // zero one channel's ring
    S_SAMPLE = 8'b0000_1000,   // write new sample, set up walk
    S_MAC    = 8'b0001_0000,   // one tap issued per cycle
    S_DRAIN  = 8'b0010_0000,   // wait for read and multiply stages
    S_ROUND  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000    // clip and hand to output register
  } state_t;

  state_t state, state_next;

  // configuration and per-channel state
  logic [COUNT_W-1:0] tap_count;
  logic [AW-1:0]      wpos [MAX_CHANNELS];

  // request registers
  logic                 ch_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 blk_r;
  logic [NW-1:0]        n_eff;

  // sequencer
  logic [NW-1:0]  k;
  logic [AW-1:0]  rd;
  logic [HAW-1:0] sweep;
  logic           rd_v;
  logic           prod_v;

  // datapath
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rsum;

  // RAM ports
  logic             tap_we;
  logic [AW-1:0]    tap_waddr;
  logic [AW-1:0]    tap_raddr;
  logic [TAP_W-1:0] tap_q;
  logic             hist_we;
  logic [HAW-1:0]   hist_waddr;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic [HAW-1:0]   hist_raddr;
  logic [SAMPLE_W-1:0] hist_q;

  // request decode
  logic          accept;
  logic          ch_ok;
  logic          idx_ok;
  logic [CW-1:0] tc_ext;
  logic [NW-1:0] n_clamp;
  logic [CHW-1:0] ch_idx;
  logic [AW-1:0] wp_cur;
  logic [NW-1:0] wp_inc;
  logic          out_free;
  logic signed [QW-1:0] q;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign ch_ok    = 32'(channel) < MAX_CHANNELS;
  assign idx_ok   = 32'(tap_index) < MAX_TAPS;
  assign ch_idx   = CHW'(ch_r);
  assign out_free = !out_valid || !out_stall;

  // tap count clamp: zero acts as one, above MAX_TAPS acts as MAX_TAPS
  always_comb begin
    tc_ext = CW'(tap_count);
    if (tc_ext == '0) begin
      n_clamp = NW'(1);
    end else if (tc_ext > CW'(MAX_TAPS)) begin
      n_clamp = NW'(MAX_TAPS);
    end else begin
      n_clamp = NW'(tc_ext);
    end
  end

  // stale write position after the count shrank restarts at slot 0
  assign wp_cur = (NW'(wpos[ch_idx]) >= n_eff) ? '0 : wpos[ch_idx];
  assign wp_inc = NW'(wp_cur) + NW'(1);

  // taps are written straight from the request port
  always_comb begin
    tap_we    = 1'b0;
    tap_waddr = AW'(tap_index);
    if (accept && ch_ok && idx_ok && (mode_t'(mode) == MODE_LOAD)) begin
      tap_we = 1'b1;
    end
  end

  assign tap_raddr  = AW'(k);
  assign hist_raddr = HAW'({ch_idx, rd});

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = sweep;
    hist_wdata = '0;
    case (state)
      S_INIT: begin
        hist_we = 1'b1;
      end
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = HAW'({ch_idx, sweep[AW-1:0]});
      end
      S_SAMPLE: begin
        hist_we    = 1'b1;
        hist_waddr = HAW'({ch_idx, wp_cur});
        hist_wdata = sample_r;
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep == HAW'(HD - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && ch_ok) begin
          case (mode_t'(mode))
            MODE_FILTER: state_next = S_SAMPLE;
            MODE_CLEAR:  state_next = S_CLEAR;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (sweep == HAW'(MAX_TAPS - 1)) state_next = S_IDLE;
      end
      S_SAMPLE: state_next = S_MAC;
      S_MAC: begin
        if (k == n_eff - NW'(1)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_v && !prod_v) state_next = S_ROUND;
      end
      S_ROUND:  state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      tap_count <= TAP_COUNT_RESET;
      sweep     <= '0;
      k         <= '0;
      rd        <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wpos[i] <= '0;
      end
    end else begin
      state  <= state_next;
      rd_v   <= (state == S_MAC);
      prod_v <= rd_v;

      if (cfg_we) begin
        tap_count <= cfg_wdata;
      end

      case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + HAW'(1);
        end
        S_IDLE: begin
          sweep <= '0;
        end
        S_SAMPLE: begin
          k  <= '0;
          rd <= wp_cur;
          wpos[ch_idx] <= (wp_inc == n_eff) ? '0 : AW'(wp_inc);
        end
        S_MAC: begin
          k  <= k + NW'(1);
          rd <= (rd == '0) ? AW'(n_eff - NW'(1)) : rd - AW'(1);
        end
        default: begin
          k <= k;
        end
      endcase

      if (state == S_CLEAR && state_next == S_IDLE) begin
        wpos[ch_idx] <= '0;
      end

      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and the shared multiply-accumulate
  assign q = rsum[ACC_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= channel;
      sample_r <= sample_in;
      blk_r    <= block_end;
      n_eff    <= n_clamp;
    end
    prod <= $signed(tap_q) * $signed(hist_q);
    if (state == S_SAMPLE) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_ROUND) begin
      rsum <= acc + ROUND_C;
    end
    if (state == S_FINISH && out_free) begin
      out_channel   <= ch_r;
      last_of_block <= blk_r;
      if (q > Q_MAX) begin
        sample_out <= SAMPLE_W'(Q_MAX);
        saturated  <= 1'b1;
      end else if (q < Q_MIN) begin
        sample_out <= SAMPLE_W'(Q_MIN);
        saturated  <= 1'b1;
      end else begin
        sample_out <= SAMPLE_W'(q);
        saturated  <= 1'b0;
      end
    end
  end

  fir_ram #(
    .WIDTH (TAP_W),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_value),
    .raddr (tap_raddr),
    .rdata (tap_q)
  );

  fir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HD)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  // checks
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (k < n_eff))
    else $error("tap counter ran past the tap count");

  a_rd_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (NW'(rd) < n_eff))
    else $error("ring read pointer outside the ring");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (!rd_v && !prod_v))
    else $error("rounding started with products in flight");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire
